FILE: hw/rtl/itwt_pkg.sv
// Package for the integer to word tokens unit: widths, word codes and the
// shift-and-adjust step of the binary to decimal conversion. No dependencies.

package itwt_pkg;

  localparam int VALUE_W    = 31;
  localparam int WORD_W     = 5;
  localparam int DIGITS     = 10;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int SHIFT_W    = 32;
  localparam int CONV_STEPS = SHIFT_W / 2;
  localparam int CNT_W      = $clog2(CONV_STEPS);

  localparam logic [WORD_W-1:0] W_ZERO     = 5'd0;
  localparam logic [WORD_W-1:0] W_HUNDRED  = 5'd28;
  localparam logic [WORD_W-1:0] W_THOUSAND = 5'd29;
  localparam logic [WORD_W-1:0] W_MILLION  = 5'd30;
  localparam logic [WORD_W-1:0] W_BILLION  = 5'd31;
  localparam logic [WORD_W-1:0] TENS_BASE  = 5'd18;
  localparam logic [WORD_W-1:0] TEEN_BASE  = 5'd10;

  // One double-dabble step: adjust every digit of five or more by three,
  // then shift the next binary bit in at the bottom.
  function automatic logic [BCD_W-1:0] dd_shift(input logic [BCD_W-1:0] bcd,
                                                input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

FILE: hw/rtl/itwt_if.sv
// Handshake channels of the integer to word tokens unit: the request
// channel carrying the value and the result channel carrying one word.
// Depends on itwt_pkg.

interface itwt_req_if import itwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itwt_rsp_if import itwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

FILE: hw/rtl/integer_to_word_tokens_unit.sv
// Top level of the integer to word tokens unit: spells a 31-bit value as a
// run of English word codes. Depends on itwt_pkg and the channels in itwt_if.

// A request is taken only while the unit is idle. The value first goes
// through binary to decimal conversion, two bits a cycle through chained
// add-three-and-shift steps. The sequencer then walks the four groups
// (billion, million, thousand, units), five word slots per group, sending
// at most one word per cycle through the output register and holding while
// a result is stalled; a zero value instead sends its single word.

module integer_to_word_tokens_unit import itwt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  itwt_req_if.sink      req,
  itwt_rsp_if.source    rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_ZERO = 2'd3;

  localparam logic [2:0] PH_H  = 3'd0;
  localparam logic [2:0] PH_HW = 3'd1;
  localparam logic [2:0] PH_T  = 3'd2;
  localparam logic [2:0] PH_U  = 3'd3;
  localparam logic [2:0] PH_S  = 3'd4;

  localparam logic [1:0] G_BILLION  = 2'd0;
  localparam logic [1:0] G_MILLION  = 2'd1;
  localparam logic [1:0] G_THOUSAND = 2'd2;
  localparam logic [1:0] G_UNITS    = 2'd3;

  logic [1:0]         state;
  logic [SHIFT_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;
  logic [1:0]         grp;
  logic [2:0]         phase;
  logic               is_zero;
  logic               out_valid;
  logic [WORD_W-1:0]  out_word;
  logic               out_last;

  logic [3:0]         h, t, u;
  logic [WORD_W-1:0]  scale;
  logic               has_scale;
  logic               later_nz;
  logic               grp_nz;
  logic [3:0]         nz;
  logic               tok_valid;
  logic [WORD_W-1:0]  tok_word;
  logic               tok_more;
  logic               slot_free;
  logic               accept;

  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.word  = out_word;
  assign rsp.last  = out_last;

  assign nz[0] = |bcd[39:36];
  assign nz[1] = |bcd[35:24];
  assign nz[2] = |bcd[23:12];
  assign nz[3] = |bcd[11:0];

  always_comb begin
    unique case (grp)
      G_BILLION: begin
        h = 4'd0; t = 4'd0; u = bcd[39:36];
        scale = W_BILLION; has_scale = 1'b1;
        later_nz = nz[1] || nz[2] || nz[3];
      end
      G_MILLION: begin
        h = bcd[35:32]; t = bcd[31:28]; u = bcd[27:24];
        scale = W_MILLION; has_scale = 1'b1;
        later_nz = nz[2] || nz[3];
      end
      G_THOUSAND: begin
        h = bcd[23:20]; t = bcd[19:16]; u = bcd[15:12];
        scale = W_THOUSAND; has_scale = 1'b1;
        later_nz = nz[3];
      end
      default: begin
        h = bcd[11:8]; t = bcd[7:4]; u = bcd[3:0];
        scale = W_ZERO; has_scale = 1'b0;
        later_nz = 1'b0;
      end
    endcase
  end

  assign grp_nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);

  always_comb begin
    tok_valid = 1'b0;
    tok_word  = W_ZERO;
    tok_more  = 1'b0;
    unique case (phase)
      PH_H: begin
        tok_valid = (h != 4'd0);
        tok_word  = {1'b0, h};
        tok_more  = 1'b1;
      end
      PH_HW: begin
        tok_valid = (h != 4'd0);
        tok_word  = W_HUNDRED;
        tok_more  = (t != 4'd0) || (u != 4'd0) || has_scale;
      end
      PH_T: begin
        if (t >= 4'd2) begin
          tok_valid = 1'b1;
          tok_word  = TENS_BASE + {1'b0, t};
          tok_more  = (u != 4'd0) || has_scale;
        end else if (t == 4'd1) begin
          tok_valid = 1'b1;
          tok_word  = TEEN_BASE + {1'b0, u};
          tok_more  = has_scale;
        end else begin
          tok_valid = (u != 4'd0);
          tok_word  = {1'b0, u};
          tok_more  = has_scale;
        end
      end
      PH_U: begin
        tok_valid = (t >= 4'd2) && (u != 4'd0);
        tok_word  = {1'b0, u};
        tok_more  = has_scale;
      end
      PH_S: begin
        tok_valid = has_scale && grp_nz;
        tok_word  = scale;
        tok_more  = 1'b0;
      end
      default: begin
        tok_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      grp   <= G_BILLION;
      phase <= PH_H;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
            cnt   <= '0;
          end
        end
        S_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CONV_STEPS - 1)) begin
            state <= is_zero ? S_ZERO : S_EMIT;
            grp   <= G_BILLION;
            phase <= PH_H;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (phase == PH_S) begin
              phase <= PH_H;
              grp   <= grp + 1'b1;
              if (grp == G_UNITS) begin
                state <= S_IDLE;
              end
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        default: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin     <= {{(SHIFT_W - VALUE_W){1'b0}}, req.value};
      bcd     <= '0;
      is_zero <= (req.value == '0);
    end else if (state == S_CONV) begin
      bcd <= dd_shift(dd_shift(bcd, bin[SHIFT_W-1]), bin[SHIFT_W-2]);
      bin <= {bin[SHIFT_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && slot_free && tok_valid) begin
      out_valid <= 1'b1;
    end else if (state == S_ZERO && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && slot_free && tok_valid) begin
      out_word <= tok_word;
      out_last <= !tok_more && !later_nz;
    end else if (state == S_ZERO && slot_free) begin
      out_word <= W_ZERO;
      out_last <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/itwt_checker.sv
// Port-level checker for the integer to word tokens unit, attached to the
// top level by the bind statement at the end. Depends on itwt_pkg.

module itwt_checker import itwt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [WORD_W-1:0] rsp_word,
  input logic              rsp_last
);

  // A stalled result holds its word and flag.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_last))
    else $error("stalled result changed");

  // The unit stays busy after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after a request");

  // The decimal conversion keeps the unit busy for its full length.
  a_conv_len: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##16 !req_ready)
    else $error("request finished too early");

  // The word Zero is only ever a run of its own.
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word == W_ZERO |-> rsp_last)
    else $error("Zero word not flagged last");

endmodule

bind integer_to_word_tokens_unit itwt_checker u_itwt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_word  (rsp.word),
  .rsp_last  (rsp.last)
);
